// ===== rtl/core/lcg_lagged_fib_bounded_rng_core_defines.svh =====
// Assertion macros shared by the generator RTL
`ifndef LCG_LAGGED_FIB_BOUNDED_RNG_CORE_DEFINES_SVH
`define LCG_LAGGED_FIB_BOUNDED_RNG_CORE_DEFINES_SVH
// clocked check, masked while in reset
`define LFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check that also holds through reset
`define LFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/lfb_pkg.sv =====
// Shared types, constants and functions of the bounded generator
package lfb_pkg;
  localparam int TABLE_DEPTH_DEF = 63;
  localparam int SEED_ROUNDS = 10;
  localparam int RETRY_W = 20;
  localparam int DIV_W = 29;
  localparam int VAL_W = 28;
  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  localparam logic [31:0] SPAN28 = 32'h1000_0000;

  typedef enum logic [1:0] {
    CMD_DRAW = 2'd0,
    CMD_SEED = 2'd1,
    CMD_LOAD = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ERR  = 2'd1,
    RES_VAL  = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic      cap_in;
    logic      load_lcg;
    logic      div_start_n;
    logic      div_start_q;
    logic      div_step;
    logic      latch_n;
    logic      lcg_adv;
    logic      tbl_rd;
    logic      tbl_wr;
    logic      fill_start;
    logic      fill_step;
    logic      res_load;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic big;
    logic small_m;
    logic quick;
    logic div_done;
    logic accept;
    logic fill_last;
  } dp_stat_t;

  function automatic logic [31:0] lcg_next(input logic [31:0] x);
    logic [31:0] p;
    p = x * LCG_MUL;
    return p + LCG_ADD;
  endfunction
endpackage

// ===== rtl/core/lfb_ram.sv =====
// Generic single-write, single-read RAM with registered read
module lfb_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/core/lfb_dpath.sv =====
// Datapath: LCG, lagged table, shared divider, result register
module lfb_dpath #(
  parameter int TABLE_DEPTH = lfb_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [39:0]      in_data,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  lfb_pkg::dp_cmd_t cmd,
  output lfb_pkg::dp_stat_t stat,
  output logic [31:0]      out_data
);
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int DW = lfb_pkg::DIV_W;
  localparam int CW = $clog2(DW + 1);

  logic              quick_r;
  logic [1:0]        cmd_r;
  logic [31:0]       op_r;
  logic [31:0]       lcg_r;
  logic [31:0]       rnd_r;
  logic [31:0]       here_r;
  logic [31:0]       fill_r;
  logic [PW-1:0]     place_r, nxt_r, idx_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [DW-1:0]     n_r, rem_r, quo_r, dvd_r, dsr_r;
  logic [CW-1:0]     cnt_r;
  logic [27:0]       val_r;
  logic              err_r;

  logic [PW-1:0]     nxt;
  logic [31:0]       rdata, sum, lcg_o, wdata;
  logic [PW-1:0]     waddr;
  logic              we;
  logic [DW:0]       rem_sh;
  logic              ge;
  logic [DW:0]       rem_sub;

  assign nxt = (place_r == PW'(TABLE_DEPTH - 1)) ? '0 : place_r + 1'b1;
  assign sum = (valid_r[nxt_r] ? rdata : 32'd0) + here_r;
  assign lcg_o = lfb_pkg::lcg_next(cmd.fill_step ? fill_r : lcg_r);
  assign we = cmd.tbl_wr | cmd.fill_step;
  assign waddr = cmd.fill_step ? idx_r : nxt_r;
  assign wdata = cmd.fill_step ? fill_r : sum;

  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign ge = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  lfb_ram #(.W(32), .D(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (nxt),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quick_r <= 1'b1;
      lcg_r <= '0;
      here_r <= '0;
      place_r <= '0;
      valid_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        quick_r <= cfg_wdata;
      end
      if (cmd.load_lcg) begin
        lcg_r <= op_r;
      end
      if (cmd.lcg_adv) begin
        lcg_r <= lcg_o;
      end
      if (cmd.tbl_wr) begin
        here_r <= sum;
        place_r <= nxt_r;
      end
      if (cmd.fill_step && idx_r == place_r) begin
        here_r <= fill_r;
      end
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (cmd.div_start_n || cmd.div_start_q) begin
        cnt_r <= CW'(DW);
      end else if (cmd.div_step && cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cmd_r <= in_data[1:0];
      op_r <= in_data[33:2];
    end
    if (cmd.lcg_adv) begin
      rnd_r <= lcg_o;
    end
    if (cmd.tbl_wr) begin
      rnd_r <= sum;
    end
    if (cmd.tbl_rd) begin
      nxt_r <= nxt;
    end
    if (cmd.fill_start) begin
      fill_r <= op_r;
      idx_r <= '0;
    end
    if (cmd.fill_step) begin
      fill_r <= lcg_o;
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.div_start_n) begin
      dvd_r <= DW'(lfb_pkg::SPAN28);
      dsr_r <= op_r[DW-1:0];
      rem_r <= '0;
    end else if (cmd.div_start_q) begin
      dvd_r <= {1'b0, rnd_r[31:4]};
      dsr_r <= n_r;
      rem_r <= '0;
    end else if (cmd.div_step && cnt_r != '0) begin
      rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
    end
    if (cmd.latch_n) begin
      n_r <= quo_r;
    end
    if (cmd.res_load) begin
      val_r <= (cmd.res_kind == lfb_pkg::RES_VAL) ? quo_r[27:0] : '0;
      err_r <= (cmd.res_kind == lfb_pkg::RES_ERR);
    end
  end

  assign stat.cmd = lfb_pkg::cmd_t'(cmd_r);
  assign stat.big = op_r > lfb_pkg::SPAN28;
  assign stat.small_m = op_r <= 32'd1;
  assign stat.quick = quick_r;
  assign stat.div_done = cnt_r == '0;
  assign stat.accept = {3'b0, quo_r} < op_r;
  assign stat.fill_last = idx_r == PW'(TABLE_DEPTH - 1);
  assign out_data = {3'b0, err_r, val_r};
endmodule

// ===== rtl/core/lfb_ctrl.sv =====
// Controller state machine of the bounded generator
`include "lcg_lagged_fib_bounded_rng_core_defines.svh"
module lfb_ctrl #(
  parameter int TABLE_DEPTH = lfb_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  lfb_pkg::dp_stat_t stat,
  output lfb_pkg::dp_cmd_t  cmd
);
  localparam int MIX_N = TABLE_DEPTH * lfb_pkg::SEED_ROUNDS;
  localparam int MW = $clog2(MIX_N);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_NDIV, S_ADV, S_TWR, S_QSTART, S_QDIV,
    S_FILL, S_MRD, S_MWR, S_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  lfb_pkg::res_kind_t       kind_r, kind_nxt;
  logic [lfb_pkg::RETRY_W-1:0] retry_r, retry_nxt;
  logic [MW-1:0]            mix_r, mix_nxt;
  logic                     out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    kind_nxt = kind_r;
    retry_nxt = retry_r;
    mix_nxt = mix_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd = '0;
    cmd.res_kind = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          retry_nxt = '0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        kind_nxt = lfb_pkg::RES_ZERO;
        state_nxt = S_DONE;
        unique case (stat.cmd)
          lfb_pkg::CMD_DRAW: begin
            if (stat.big) begin
              kind_nxt = lfb_pkg::RES_ERR;
            end else if (!stat.small_m) begin
              cmd.div_start_n = 1'b1;
              state_nxt = S_NDIV;
            end
          end
          lfb_pkg::CMD_SEED: begin
            cmd.fill_start = 1'b1;
            state_nxt = S_FILL;
          end
          lfb_pkg::CMD_LOAD: cmd.load_lcg = 1'b1;
          default: ;
        endcase
      end
      S_NDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.latch_n = 1'b1;
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        if (stat.quick) begin
          cmd.lcg_adv = 1'b1;
          state_nxt = S_QSTART;
        end else begin
          cmd.tbl_rd = 1'b1;
          state_nxt = S_TWR;
        end
      end
      S_TWR: begin
        cmd.tbl_wr = 1'b1;
        state_nxt = S_QSTART;
      end
      S_QSTART: begin
        cmd.div_start_q = 1'b1;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          priority if (stat.accept) begin
            kind_nxt = lfb_pkg::RES_VAL;
            state_nxt = S_DONE;
          end else if (&retry_r) begin
            kind_nxt = lfb_pkg::RES_ZERO;
            state_nxt = S_DONE;
          end else begin
            retry_nxt = retry_r + 1'b1;
            state_nxt = S_ADV;
          end
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          mix_nxt = '0;
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        cmd.tbl_rd = 1'b1;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.tbl_wr = 1'b1;
        if (mix_r == MW'(MIX_N - 1)) begin
          state_nxt = S_DONE;
        end else begin
          mix_nxt = mix_r + 1'b1;
          state_nxt = S_MRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.res_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r <= lfb_pkg::RES_ZERO;
      retry_r <= '0;
      mix_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r <= kind_nxt;
      retry_r <= retry_nxt;
      mix_r <= mix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

  `LFB_ASSERT(a_accept_decodes, in_tvalid && in_tready |=> state_r == S_DEC, "no decode")
  `LFB_ASSERT(a_idle_retry_clear, state_r == S_DEC |-> retry_r == '0, "retry not cleared")
  `LFB_ASSERT(a_done_holds, state_r == S_DONE && out_valid_r && !out_tready |=> state_r == S_DONE, "result dropped")
  `LFB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r, "reset state")
endmodule

// ===== rtl/core/lcg_lagged_fib_bounded_rng_core.sv =====
// Bounded generator with LCG and additive lagged table engines
// To out_tvalid: load/unused/trivial draw goes from decode straight to done; a draw
// finds n, then per attempt steps the LCG or table and divides (shared 29-step
// bit-serial divider for n and quotient). Seed: fill, then mix (one RAM port pair).
// One word in flight; a finished result waits in the output register.
// Reset: synchronous rst_n, quick_mode=1, LCG 0, table reads as zero, place 0.
module lcg_lagged_fib_bounded_rng_core #(
  parameter int TABLE_DEPTH = lfb_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], operand[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // drawn value[27:0], range_error[28], zero pad
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  lfb_pkg::dp_cmd_t  cmd;
  lfb_pkg::dp_stat_t stat;

  lfb_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lfb_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_tdata)
  );
endmodule
